FILE: src/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, constants and helpers for the symmetric pivot column swap unit.
// ----------------------------------------------------------------------------
package spc_pkg;

	// storage geometry
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;

	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
	localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W  = $clog2(MAX_COLS + 1);

	// field widths
	localparam int ACT_W    = 2;
	localparam int IDX_IN_W = 6;
	localparam int WORD_W   = 64;
	localparam int PIV_W    = 8;
	localparam int STAT_W   = 2;
	localparam int CFG_W    = 7;
	localparam int CFGI_W   = 2;

	// signed walk index, wide enough for -1, the column count and any target
	localparam int IDX_W = (CCNT_W + 1 > PIV_W + 1) ? CCNT_W + 1 : PIV_W + 1;

	// actions
	localparam logic [ACT_W-1:0] ACT_WRITE_ELEM  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE_PIVOT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_APPLY       = 2'd2;
	localparam logic [ACT_W-1:0] ACT_READ_ELEM   = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_SKIP = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_NOP  = 2'd2;

	// configuration register indexes
	localparam logic [CFGI_W-1:0] CFG_UPPER = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_DIR   = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_ROWS  = 2'd2;
	localparam logic [CFGI_W-1:0] CFG_COLS  = 2'd3;

	// walk directions
	localparam logic [1:0] DIR_FWD = 2'd0;
	localparam logic [1:0] DIR_BWD = 2'd1;

	// reset values
	localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
	localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic [IDX_IN_W-1:0]     row;
		logic [IDX_IN_W-1:0]     column;
		logic [WORD_W-1:0]       element_value;
		logic signed [PIV_W-1:0] pivot_code;
	} spc_cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic [STAT_W-1:0] status;
	} spc_result_t;

	// column-major word address
	function automatic logic [ADDR_W-1:0] mat_addr(input logic [COL_W-1:0] col,
	                                               input logic [ROW_W-1:0] row);
		mat_addr = ADDR_W'(col) * ADDR_W'(MAX_ROWS) + ADDR_W'(row);
	endfunction

endpackage

FILE: src/spc_ram.sv
// ----------------------------------------------------------------------------
// spc_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module spc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/apply_symmetric_pivot_column_swaps_unit.sv
// ----------------------------------------------------------------------------
// apply_symmetric_pivot_column_swaps_unit
// Matrix word store and pivot list with a column interchange walker for
// symmetric-indefinite pivot lists.
// ----------------------------------------------------------------------------
// Element/pivot writes and element reads give their result in the cycle after
//   the transfer; one such command is taken every cycle while not busy.
// Apply: each slot reads and evaluates its code, a 2x2 block also its partner's;
//   each row of a column swap takes read A, read B, write A, write B; a closing
//   check ends the walk (none if a block lacks its partner); result the cycle after.
// Reset clears control state and the configuration registers; the matrix and
//   pivot RAMs are not cleared. Results cannot be stalled by the receiver.
module apply_symmetric_pivot_column_swaps_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  spc_pkg::spc_cmd_t            cmd,
	output logic                         done,
	output spc_pkg::spc_result_t         result,
	input  logic                         cfg_we,
	input  logic [spc_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [spc_pkg::CFG_W-1:0]    cfg_data
);
	import spc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PV_RD,
		ST_PV_EV,
		ST_PT_EV,
		ST_SW_RA,
		ST_SW_RB,
		ST_SW_WA,
		ST_SW_WB
	} state_t;

	state_t state_q;

	// configuration
	logic             upper_q;
	logic [1:0]       dir_q;
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;

	// walk state
	logic signed [IDX_W-1:0] k_q;
	logic signed [PIV_W-1:0] code_q;
	logic                    flag_q;
	logic [COL_W-1:0]        ca_q;
	logic [COL_W-1:0]        cb_q;
	logic [RCNT_W-1:0]       r_q;
	logic [WORD_W-1:0]       a_q;

	// result registers
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic              rd_s1;

	// memory ports
	logic              mat_we;
	logic [ADDR_W-1:0] mat_waddr;
	logic [WORD_W-1:0] mat_wdata;
	logic [ADDR_W-1:0] mat_raddr;
	logic [WORD_W-1:0] mat_rdata;
	logic              pv_we;
	logic [COL_W-1:0]  pv_raddr;
	logic [PIV_W-1:0]  pv_rdata;

	// helpers
	logic                    accept;
	logic                    cmd_inside;
	logic [RCNT_W-1:0]       m_n;
	logic [CCNT_W-1:0]       n_n;
	logic signed [IDX_W-1:0] n_s;
	logic signed [IDX_W-1:0] end_s;
	logic signed [IDX_W-1:0] k_next;
	logic signed [IDX_W-1:0] pt_next;
	logic signed [IDX_W-1:0] code_ext;
	logic signed [IDX_W-1:0] codeq_ext;
	logic signed [IDX_W-1:0] kp_one;
	logic signed [IDX_W-1:0] kp_blk;
	logic signed [IDX_W-1:0] blk_col;
	logic [ADDR_W-1:0]       addr_a;
	logic [ADDR_W-1:0]       addr_b;
	logic [ADDR_W-1:0]       addr_cmd;

	assign accept     = start && (state_q == ST_IDLE);
	assign cmd_inside = (32'(cmd.row) < MAX_ROWS) && (32'(cmd.column) < MAX_COLS);

	// effective counts and walk arithmetic
	always_comb begin
		m_n       = (32'(rows_q) < MAX_ROWS) ? RCNT_W'(rows_q) : RCNT_W'(MAX_ROWS);
		n_n       = (32'(cols_q) < MAX_COLS) ? CCNT_W'(cols_q) : CCNT_W'(MAX_COLS);
		n_s       = $signed(IDX_W'(n_n));
		end_s     = (dir_q == DIR_BWD) ? -IDX_W'(1) : n_s;
		k_next    = (dir_q == DIR_BWD) ? k_q - IDX_W'(1) : k_q + IDX_W'(1);
		pt_next   = (dir_q == DIR_BWD) ? k_next - IDX_W'(1) : k_next + IDX_W'(1);
		code_ext  = {{(IDX_W-PIV_W){pv_rdata[PIV_W-1]}}, pv_rdata};
		codeq_ext = {{(IDX_W-PIV_W){code_q[PIV_W-1]}}, code_q};
		kp_one    = code_ext - IDX_W'(1);
		kp_blk    = ~codeq_ext;
		// upper storage takes the lower column of the pair
		if (upper_q) begin
			blk_col = (k_q < k_next) ? k_q : k_next;
		end else begin
			blk_col = (k_q < k_next) ? k_next : k_q;
		end
		addr_a   = mat_addr(ca_q, r_q[ROW_W-1:0]);
		addr_b   = mat_addr(cb_q, r_q[ROW_W-1:0]);
		addr_cmd = mat_addr(COL_W'(cmd.column), ROW_W'(cmd.row));
	end

	// matrix port steering
	always_comb begin
		mat_raddr = addr_cmd;
		mat_we    = 1'b0;
		mat_waddr = addr_cmd;
		mat_wdata = cmd.element_value;
		case (state_q)
			ST_IDLE: begin
				mat_we = accept && (cmd.action == ACT_WRITE_ELEM) && cmd_inside;
			end
			ST_SW_RA: begin
				mat_raddr = addr_a;
			end
			ST_SW_RB: begin
				mat_raddr = addr_b;
			end
			ST_SW_WA: begin
				mat_we    = 1'b1;
				mat_waddr = addr_a;
				mat_wdata = mat_rdata;
			end
			ST_SW_WB: begin
				mat_we    = 1'b1;
				mat_waddr = addr_b;
				mat_wdata = a_q;
			end
			default: begin
				mat_we = 1'b0;
			end
		endcase
	end

	// pivot port steering
	always_comb begin
		pv_we = accept && (cmd.action == ACT_WRITE_PIVOT) && (32'(cmd.column) < MAX_COLS);
		case (state_q)
			ST_PV_RD: pv_raddr = k_q[COL_W-1:0];
			ST_PV_EV: pv_raddr = k_next[COL_W-1:0];
			default:  pv_raddr = '0;
		endcase
	end

	spc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	spc_ram #(.WIDTH(PIV_W), .DEPTH(MAX_COLS)) u_piv_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (COL_W'(cmd.column)),
		.wdata (cmd.pivot_code),
		.raddr (pv_raddr),
		.rdata (pv_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 1'b0;
			dir_q   <= DIR_FWD;
			rows_q  <= ROWS_RESET;
			cols_q  <= COLS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UPPER: upper_q <= cfg_data[0];
				CFG_DIR:   dir_q   <= cfg_data[1:0];
				CFG_ROWS:  rows_q  <= cfg_data;
				CFG_COLS:  cols_q  <= cfg_data;
				default:   upper_q <= upper_q;
			endcase
		end
	end

	// walk sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			status_q <= STATUS_OK;
			rd_s1    <= 1'b0;
			flag_q   <= 1'b0;
			k_q      <= '0;
			r_q      <= '0;
		end else begin
			done_q <= 1'b0;
			rd_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= STATUS_OK;
						case (cmd.action)
							ACT_APPLY: begin
								flag_q <= 1'b0;
								case (dir_q)
									DIR_FWD: begin
										k_q     <= '0;
										state_q <= ST_PV_RD;
									end
									DIR_BWD: begin
										k_q     <= n_s - IDX_W'(1);
										state_q <= ST_PV_RD;
									end
									default: begin
										done_q   <= 1'b1;
										status_q <= STATUS_NOP;
									end
								endcase
							end
							ACT_READ_ELEM: begin
								done_q <= 1'b1;
								rd_s1  <= cmd_inside;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PV_RD: begin
					if (k_q == end_s) begin
						done_q   <= 1'b1;
						status_q <= flag_q ? STATUS_SKIP : STATUS_OK;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_PV_EV;
					end
				end
				ST_PV_EV: begin
					if (code_ext > 0) begin
						// one-column pivot
						k_q     <= k_next;
						state_q <= ST_PV_RD;
						if (kp_one >= n_s) begin
							flag_q <= 1'b1;
						end else if (kp_one != k_q && m_n != '0) begin
							ca_q    <= k_q[COL_W-1:0];
							cb_q    <= kp_one[COL_W-1:0];
							r_q     <= '0;
							state_q <= ST_SW_RA;
						end
					end else if (k_next < 0 || k_next >= n_s) begin
						// block partner missing ends the walk
						done_q   <= 1'b1;
						status_q <= STATUS_SKIP;
						state_q  <= ST_IDLE;
					end else begin
						code_q  <= pv_rdata;
						state_q <= ST_PT_EV;
					end
				end
				ST_PT_EV: begin
					// partner code is on the pivot read port
					k_q     <= pt_next;
					state_q <= ST_PV_RD;
					if (kp_blk < 0 || kp_blk >= n_s) begin
						flag_q <= 1'b1;
					end else if (pv_rdata == code_q && blk_col != kp_blk && m_n != '0) begin
						ca_q    <= blk_col[COL_W-1:0];
						cb_q    <= kp_blk[COL_W-1:0];
						r_q     <= '0;
						state_q <= ST_SW_RA;
					end
				end
				ST_SW_RA: begin
					state_q <= ST_SW_RB;
				end
				ST_SW_RB: begin
					a_q     <= mat_rdata;
					state_q <= ST_SW_WA;
				end
				ST_SW_WA: begin
					state_q <= ST_SW_WB;
				end
				ST_SW_WB: begin
					if (RCNT_W'(r_q + 1'b1) == m_n) begin
						state_q <= ST_PV_RD;
					end else begin
						r_q     <= RCNT_W'(r_q + 1'b1);
						state_q <= ST_SW_RA;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign result.read_value = rd_s1 ? mat_rdata : '0;
	assign result.status     = status_q;

	// a read result always comes with the strobe and a clean status
	a_read_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (done_q && status_q == STATUS_OK))
		else $error("read data without result strobe");

	// results are only strobed once the walker is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while walker active");

	// the walker only starts from an accepted apply
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) && $past(cmd.action) == ACT_APPLY))
		else $error("walker started without apply");

	// a swap never pairs a column with itself
	a_swap_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SW_RA) |-> (ca_q != cb_q))
		else $error("swap of a column with itself");

	// matrix writes during apply come only from the swap write states
	a_swap_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(mat_we && busy) |-> (state_q == ST_SW_WA || state_q == ST_SW_WB))
		else $error("matrix write outside swap");

endmodule

FILE: tb/sv/column_swap_checker.sv
// ----------------------------------------------------------------------------
// column_swap_checker
// Watches the command, result and register channels of the pivot column
// swap unit. It keeps its own copy of the matrix words, the pivot codes and
// the registers, predicts one result per command transfer and compares each
// result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module column_swap_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  spc_pkg::spc_cmd_t          cmd,
	input  logic                       done,
	input  spc_pkg::spc_result_t       result,
	input  logic                       cfg_we,
	input  logic [spc_pkg::CFGI_W-1:0] cfg_index,
	input  logic [spc_pkg::CFG_W-1:0]  cfg_data,
	output int                         mismatches,
	output int                         outstanding
);
	import spc_pkg::*;

	// predicted storage, words indexed [column][row]
	logic [WORD_W-1:0]       words [MAX_COLS][MAX_ROWS];
	logic signed [PIV_W-1:0] codes [MAX_COLS];

	// register copies
	logic             upper_cfg;
	logic [1:0]       dir_cfg;
	logic [CFG_W-1:0] rows_cfg;
	logic [CFG_W-1:0] cols_cfg;

	spc_result_t owed_results [$];
	spc_result_t want;
	spc_result_t oldest;

	initial mismatches = 0;

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// exchange the first m rows of two columns
	function automatic void swap_columns(input int a, input int b, input int m);
		logic [WORD_W-1:0] t;
		for (int r = 0; r < m; r++) begin
			t = words[a][r];
			words[a][r] = words[b][r];
			words[b][r] = t;
		end
	endfunction

	// walk the pivot list, swap columns and return the apply status
	function automatic logic [STAT_W-1:0] walk_pivots();
		int m, n, stp, k, stop, code, tgt, mate;
		bit flag;
		m = (rows_cfg < MAX_ROWS) ? int'(rows_cfg) : MAX_ROWS;
		n = (cols_cfg < MAX_COLS) ? int'(cols_cfg) : MAX_COLS;
		flag = 1'b0;
		if (dir_cfg == DIR_FWD) begin
			stp = 1;
			k = 0;
			stop = n;
		end else if (dir_cfg == DIR_BWD) begin
			stp = -1;
			k = n - 1;
			stop = -1;
		end else begin
			return STATUS_NOP;
		end
		while (k != stop) begin
			code = codes[k];
			if (code > 0) begin
				// single column interchange
				tgt = code - 1;
				if (tgt >= n)
					flag = 1'b1;
				else if (tgt != k)
					swap_columns(k, tgt, m);
				k += stp;
			end else begin
				// 2x2 block, the next slot in walk order is its partner
				tgt = -code - 1;
				mate = k + stp;
				if (mate < 0 || mate >= n) begin
					flag = 1'b1;
					break;
				end
				if (tgt < 0 || tgt >= n)
					flag = 1'b1;
				else if (codes[mate] == codes[k])
					swap_columns(upper_cfg ? ((k < mate) ? k : mate) :
					             ((k < mate) ? mate : k), tgt, m);
				k = mate + stp;
			end
		end
		return flag ? STATUS_SKIP : STATUS_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_cfg = 1'b0;
			dir_cfg = DIR_FWD;
			rows_cfg = ROWS_RESET;
			cols_cfg = COLS_RESET;
			owed_results.delete();
			outstanding <= 0;
		end else begin
			// result transfer against the oldest prediction
			if (done) begin
				if (owed_results.size() == 0) begin
					report("result transfer with no prediction waiting");
				end else begin
					oldest = owed_results.pop_front();
					if (result.read_value !== oldest.read_value)
						report($sformatf("read_value %h, predicted %h",
						                 result.read_value, oldest.read_value));
					if (result.status !== oldest.status)
						report($sformatf("status %0d, predicted %0d",
						                 result.status, oldest.status));
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_UPPER: upper_cfg = cfg_data[0];
					CFG_DIR:   dir_cfg = cfg_data[1:0];
					CFG_ROWS:  rows_cfg = cfg_data;
					CFG_COLS:  cols_cfg = cfg_data;
					default:   ;
				endcase
			end
			// command transfer: update the copy and predict its result
			if (start && !busy) begin
				want = '0;
				case (cmd.action)
					ACT_WRITE_ELEM:  words[cmd.column][cmd.row] = cmd.element_value;
					ACT_WRITE_PIVOT: codes[cmd.column] = cmd.pivot_code;
					ACT_APPLY:       want.status = walk_pivots();
					ACT_READ_ELEM:   want.read_value = words[cmd.column][cmd.row];
					default:         ;
				endcase
				owed_results.push_back(want);
			end
			outstanding <= owed_results.size();
		end
	end

endmodule

FILE: tb/sv/apply_symmetric_pivot_column_swaps_unit_tb.sv
// ----------------------------------------------------------------------------
// apply_symmetric_pivot_column_swaps_unit_tb
// Drives the pivot column swap unit through phases of register settings:
// loads of matrix words, pivot lists in walk order with random and faulty
// entries, noise codes, applies and read-backs, with random sender idling.
// Words are only read back where they are known to have been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apply_symmetric_pivot_column_swaps_unit_tb;
	import spc_pkg::*;

	localparam int NUM_ITEMS = 1250;
	localparam logic [1:0] DIR_IDLE     = 2'd2;
	localparam logic [1:0] DIR_IDLE_ALT = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	spc_cmd_t            cmd;
	logic                done;
	spc_result_t         result;
	logic                cfg_we;
	logic [CFGI_W-1:0]   cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	int                  mismatches;
	int                  outstanding;

	// stimulus state
	int         idle_pct;
	int         sent;
	int         m_now;
	int         n_now;
	logic [1:0] dir_now;
	bit         known [MAX_ROWS][MAX_COLS];

	apply_symmetric_pivot_column_swaps_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	column_swap_checker swap_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end

	function automatic spc_cmd_t rand_cmd(input logic [ACT_W-1:0] act);
		spc_cmd_t c;
		c.action = act;
		c.row = IDX_IN_W'($urandom);
		c.column = IDX_IN_W'($urandom);
		c.element_value = {$urandom, $urandom};
		c.pivot_code = PIV_W'($urandom);
		return c;
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		int s;
		s = $urandom_range(0, 9);
		if (s == 0)
			return '0;
		if (s == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// one command transfer, with random idle cycles ahead of it
	task automatic send(input spc_cmd_t c);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic put_word(input int row_i, input int col_i, input logic [WORD_W-1:0] v);
		spc_cmd_t c;
		c = rand_cmd(ACT_WRITE_ELEM);
		c.row = IDX_IN_W'(row_i);
		c.column = IDX_IN_W'(col_i);
		c.element_value = v;
		send(c);
		known[row_i][col_i] = 1'b1;
	endtask

	task automatic get_word(input int row_i, input int col_i);
		spc_cmd_t c;
		c = rand_cmd(ACT_READ_ELEM);
		c.row = IDX_IN_W'(row_i);
		c.column = IDX_IN_W'(col_i);
		send(c);
	endtask

	task automatic put_code(input int slot, input int code);
		spc_cmd_t c;
		c = rand_cmd(ACT_WRITE_PIVOT);
		c.column = IDX_IN_W'(slot);
		c.pivot_code = PIV_W'(code);
		send(c);
	endtask

	// apply, then forget rows whose swapped segment was not fully written
	task automatic run_apply();
		bit whole;
		send(rand_cmd(ACT_APPLY));
		if (dir_now == DIR_FWD || dir_now == DIR_BWD) begin
			for (int r = 0; r < m_now; r++) begin
				whole = 1'b1;
				for (int c = 0; c < n_now; c++)
					if (!known[r][c])
						whole = 1'b0;
				if (!whole)
					for (int c = 0; c < n_now; c++)
						known[r][c] = 1'b0;
			end
		end
	endtask

	// pivot list for the slots in use, laid out in walk order
	task automatic load_pivot_list();
		int k, j, mate, code, sel;
		k = 0;
		while (k < n_now) begin
			j = (dir_now == DIR_BWD) ? n_now - 1 - k : k;
			mate = (dir_now == DIR_BWD) ? j - 1 : j + 1;
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				// single interchange in range, self included
				put_code(j, $urandom_range(1, n_now));
				k++;
			end else if (sel < 46) begin
				// single interchange beyond the columns in use
				put_code(j, $urandom_range(n_now + 1, (n_now < 64) ? 64 : 127));
				k++;
			end else if (k == n_now - 1) begin
				// block opened on the last slot: partner missing
				put_code(j, -int'($urandom_range(0, 64)));
				k++;
			end else if (sel < 82) begin
				// matched 2x2 block
				code = -int'($urandom_range(0, n_now - 1)) - 1;
				put_code(j, code);
				put_code(mate, code);
				k += 2;
			end else if (sel < 90) begin
				// partner code differs
				code = -int'($urandom_range(0, n_now - 1)) - 1;
				put_code(j, code);
				put_code(mate, code + 1);
				k += 2;
			end else if (sel < 96) begin
				// block target out of range, or code zero
				code = $urandom_range(0, 1) ? 0 : -int'($urandom_range(n_now, 64)) - 1;
				put_code(j, code);
				put_code(mate, code);
				k += 2;
			end else begin
				put_code(j, int'($urandom_range(0, 128)) - 64);
				k++;
			end
		end
	endtask

	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic configure(input bit u, input logic [1:0] d, input int rows, input int cols);
		quiesce();
		cfg_write(CFG_UPPER, CFG_W'(u));
		cfg_write(CFG_DIR, CFG_W'(d));
		cfg_write(CFG_ROWS, CFG_W'(rows));
		cfg_write(CFG_COLS, CFG_W'(cols));
		cfg_we <= 1'b0;
		dir_now = d;
		m_now = (rows < MAX_ROWS) ? rows : MAX_ROWS;
		n_now = (cols < MAX_COLS) ? cols : MAX_COLS;
	endtask

	// cell in the filled region most of the time, anywhere otherwise
	task automatic pick_cell(input int fr, output int r, output int c);
		if (fr > 0 && n_now > 0 && $urandom_range(0, 99) < 85) begin
			r = $urandom_range(0, fr - 1);
			c = $urandom_range(0, n_now - 1);
		end else begin
			r = $urandom_range(0, MAX_ROWS - 1);
			c = $urandom_range(0, MAX_COLS - 1);
		end
	endtask

	initial begin
		int phase, i, sel, r, c, fr, tries, mix_len, w, rows, cols;
		bit hit, big;
		logic [1:0] d;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		sent = 0;
		m_now = MAX_ROWS;
		n_now = MAX_COLS;
		dir_now = DIR_FWD;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme words, one of each pivot kind, flagged walks
		configure(1'b1, DIR_FWD, 2, 4);
		put_word(0, 0, '0);
		put_word(1, 0, '1);
		put_word(0, 1, 64'h5555_5555_5555_5555);
		put_word(1, 1, 64'hAAAA_AAAA_AAAA_AAAA);
		for (c = 2; c < 4; c++)
			for (r = 0; r < 2; r++)
				put_word(r, c, rand_word());
		put_word(63, 63, '1);
		get_word(63, 63);
		put_code(0, 3);
		put_code(1, -4);
		put_code(2, -4);
		put_code(3, 64);
		run_apply();
		get_word(0, 0);
		get_word(1, 1);
		get_word(0, 3);
		put_code(3, -64);
		run_apply();
		get_word(1, 2);

		// random phases, each under its own register setting
		for (phase = 1; sent < NUM_ITEMS; phase++) begin
			case (phase)
				1: configure(1'b0, DIR_BWD, 64, 64);
				2: configure(1'b1, DIR_IDLE, 1, 1);
				3: configure(1'b0, DIR_IDLE_ALT, 0, 5);
				4: configure(1'b1, DIR_FWD, 127, 0);
				5: configure(1'b0, DIR_FWD, 3, 100);
				default: begin
					sel = $urandom_range(0, 99);
					d = (sel < 42) ? DIR_FWD : (sel < 84) ? DIR_BWD :
					    (sel < 94) ? DIR_IDLE : DIR_IDLE_ALT;
					sel = $urandom_range(0, 99);
					rows = (sel < 88) ? $urandom_range(1, 6) : (sel < 94) ? 64 :
					       (sel < 97) ? 0 : $urandom_range(65, 127);
					sel = $urandom_range(0, 99);
					cols = (sel < 85) ? $urandom_range(1, 8) : (sel < 93) ? 64 :
					       (sel < 96) ? 0 : $urandom_range(65, 127);
					configure($urandom_range(0, 1), d, rows, cols);
				end
			endcase
			case (phase % 3)
				0: idle_pct = 0;
				1: idle_pct = 52;
				default: idle_pct = 24;
			endcase
			fr = (m_now * n_now <= 48) ? m_now : $urandom_range(1, (m_now < 3) ? m_now : 3);
			big = (m_now * n_now > 1024);

			// fill the leading rows of the columns that the swaps move
			for (r = 0; r < fr; r++)
				for (c = 0; c < n_now; c++)
					put_word(r, c, rand_word());
			load_pivot_list();

			mix_len = $urandom_range(30, 60);
			for (i = 0; i < mix_len; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 35) begin
					// read back a word known to be written
					hit = 1'b0;
					for (tries = 0; tries < 24 && !hit; tries++) begin
						pick_cell(fr, r, c);
						hit = known[r][c];
					end
					if (hit)
						get_word(r, c);
					else
						put_word(r, c, rand_word());
				end else if (sel < 60) begin
					pick_cell(fr, r, c);
					put_word(r, c, rand_word());
				end else if (sel < 65) begin
					// stray pivot code, now and then outside the usual range
					put_code($urandom_range(0, MAX_COLS - 1),
					         ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 128)) - 64 :
					                                       int'($urandom_range(0, 255)) - 128);
				end else if (sel < 69) begin
					load_pivot_list();
				end else if (!big || sel >= 95) begin
					run_apply();
				end else begin
					pick_cell(fr, r, c);
					put_word(r, c, rand_word());
				end
			end
		end

		// drain the results still owed
		start <= 1'b0;
		@(posedge clk);
		for (w = 0; w < 100000 && outstanding != 0; w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: apply_symmetric_pivot_column_swaps_unit.f
src/spc_pkg.sv
src/spc_ram.sv
src/apply_symmetric_pivot_column_swaps_unit.sv
tb/sv/column_swap_checker.sv
tb/sv/apply_symmetric_pivot_column_swaps_unit_tb.sv
